/* sv/rgbrcc_pkg.sv */
// ----------------------------------------------------------------------------
// RGB ratio classifier package
// Shared constants, the built-in calibration table and pipeline types.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package rgbrcc_pkg;

    localparam int NUM_SENSORS  = 5;
    localparam int SENSOR_IDX_W = (NUM_SENSORS > 1) ? $clog2(NUM_SENSORS) : 1;

    localparam int ENTRIES      = 12;
    localparam int ENTRY_W      = 12;
    localparam int DEFAULT_SETS = 5;
    localparam int NUM_RATIOS   = 3;
    localparam int NUM_WINDOWS  = 3;
    localparam int WIN_BASE     = 3;

    localparam int SENSOR_W = 3;
    localparam int CHAN_W   = 16;
    localparam int IDX_W    = 4;
    localparam int VALUE_W  = 8;
    localparam int COLOR_W  = 2;

    localparam int S_TDATA_W = 64;
    localparam int M_TDATA_W = 8;

    // Ratio bounds are held in thousandths; written entries arrive in hundredths.
    localparam int RATIO_SCALE = 1000;
    localparam int WRITE_SCALE = 10;

    localparam int SCALED_W  = CHAN_W + 10;
    localparam int LO_PROD_W = ENTRY_W + CHAN_W;
    localparam int HI_PROD_W = ENTRY_W + 1 + CHAN_W;

    localparam logic CMD_CLASSIFY = 1'b0;
    localparam logic CMD_WRITE    = 1'b1;

    localparam logic [COLOR_W-1:0] LIGHT_NONE   = 2'd0;
    localparam logic [COLOR_W-1:0] LIGHT_MIDDLE = 2'd1;
    localparam logic [COLOR_W-1:0] LIGHT_WHITE  = 2'd2;
    localparam logic [COLOR_W-1:0] LIGHT_YELLOW = 2'd3;

    typedef logic [ENTRY_W-1:0] entry_t;
    typedef entry_t [ENTRIES-1:0] cal_row_t;

    // Load strobes of the four pipeline stages.
    typedef struct packed {
        logic ld1;
        logic ld2;
        logic ld3;
        logic ld4;
    } pipe_ctl_t;

    // Per sensor: tolerances r/g, r/b, g/b, then middle, white, yellow centers.
    localparam entry_t DEFAULT_CAL [DEFAULT_SETS][ENTRIES] = '{
        '{12'd101, 12'd150,  12'd29,  12'd1066, 12'd1426, 12'd1337,
          12'd861, 12'd1060, 12'd1232, 12'd1336, 12'd2044, 12'd1530},
        '{12'd195, 12'd326,  12'd48,  12'd1219, 12'd1685, 12'd1384,
          12'd990, 12'd1261, 12'd1275, 12'd1501, 12'd2351, 12'd1565},
        '{12'd125, 12'd981,  12'd567, 12'd1202, 12'd1679, 12'd1398,
          12'd970, 12'd1247, 12'd1285, 12'd1500, 12'd2018, 12'd1322},
        '{12'd152, 12'd245,  12'd36,  12'd1074, 12'd1465, 12'd1365,
          12'd877, 12'd1117, 12'd1275, 12'd1323, 12'd2031, 12'd1535},
        '{12'd108, 12'd1038, 12'd708, 12'd1074, 12'd1471, 12'd1370,
          12'd872, 12'd1106, 12'd1268, 12'd1338, 12'd1643, 12'd1199}
    };

endpackage

/* sv/rgbrcc_ram.sv */
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with a registered, enabled read.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module rgbrcc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              aclk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic              re,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

/* sv/rgbrcc_cal_store.sv */
// ----------------------------------------------------------------------------
// Calibration store
// One RAM per entry index, addressed by sensor, plus a valid flag per entry.
// An entry that was never written reads back its built-in default.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module rgbrcc_cal_store (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  rgbrcc_pkg::pipe_ctl_t            ctl,
    input  logic                             wr_en,
    input  logic [rgbrcc_pkg::SENSOR_W-1:0]  wr_sensor,
    input  logic [rgbrcc_pkg::IDX_W-1:0]     wr_index,
    input  logic [rgbrcc_pkg::VALUE_W-1:0]   wr_value,
    input  logic [rgbrcc_pkg::SENSOR_W-1:0]  rd_sensor,
    output rgbrcc_pkg::cal_row_t             cal_row
);

    import rgbrcc_pkg::*;

    logic [SENSOR_IDX_W-1:0] waddr;
    logic [SENSOR_IDX_W-1:0] raddr;
    logic                    rd_ok;
    entry_t                  wdata;
    entry_t                  ram_rd [ENTRIES];
    cal_row_t                def_row;

    logic [ENTRIES-1:0]  valid_reg [NUM_SENSORS];
    logic [ENTRIES-1:0]  valid_row_reg;
    logic [SENSOR_W-1:0] sensor_s1_reg;

    assign waddr = SENSOR_IDX_W'(wr_sensor);
    assign raddr = SENSOR_IDX_W'(rd_sensor);
    assign rd_ok = int'(rd_sensor) < NUM_SENSORS;

    // Value in hundredths times ten gives thousandths; at most 2550.
    assign wdata = ENTRY_W'({wr_value, 3'b000}) + ENTRY_W'({wr_value, 1'b0});

    for (genvar e = 0; e < ENTRIES; e++) begin : g_ram
        rgbrcc_ram #(
            .WIDTH(ENTRY_W),
            .DEPTH(NUM_SENSORS)
        ) u_ram (
            .aclk (aclk),
            .we   (wr_en && (wr_index == IDX_W'(e))),
            .waddr(waddr),
            .wdata(wdata),
            .re   (ctl.ld1),
            .raddr(raddr),
            .rdata(ram_rd[e])
        );
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int s = 0; s < NUM_SENSORS; s++) begin
                valid_reg[s] <= '0;
            end
        end else if (wr_en) begin
            valid_reg[waddr][wr_index] <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (ctl.ld1) begin
            valid_row_reg <= rd_ok ? valid_reg[raddr] : '0;
            sensor_s1_reg <= rd_sensor;
        end
    end

    // Sensors beyond the built-in sets default to zero.
    always_comb begin
        def_row = '0;
        for (int d = 0; d < DEFAULT_SETS; d++) begin
            if (sensor_s1_reg == SENSOR_W'(d)) begin
                for (int e = 0; e < ENTRIES; e++) begin
                    def_row[e] = DEFAULT_CAL[d][e];
                end
            end
        end
    end

    always_comb begin
        for (int e = 0; e < ENTRIES; e++) begin
            cal_row[e] = valid_row_reg[e] ? ram_rd[e] : def_row[e];
        end
    end

endmodule

/* sv/rgbrcc_window_pipe.sv */
// ----------------------------------------------------------------------------
// Window test pipeline
// Bounds, cross-multiplication and inclusive compares for the three windows,
// then the priority pick middle, white, yellow, else none.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module rgbrcc_window_pipe (
    input  logic                            aclk,
    input  rgbrcc_pkg::pipe_ctl_t           ctl,
    input  rgbrcc_pkg::cal_row_t            cal_row,
    input  logic [rgbrcc_pkg::CHAN_W-1:0]   red,
    input  logic [rgbrcc_pkg::CHAN_W-1:0]   green,
    input  logic [rgbrcc_pkg::CHAN_W-1:0]   blue,
    input  logic                            bad,
    output logic [rgbrcc_pkg::COLOR_W-1:0]  color
);

    import rgbrcc_pkg::*;

    logic [CHAN_W-1:0] num [NUM_RATIOS];
    logic [CHAN_W-1:0] den [NUM_RATIOS];

    // Stage 2: window bounds and scaled numerators.
    logic [ENTRY_W-1:0]  lo2_next    [NUM_WINDOWS][NUM_RATIOS];
    logic [ENTRY_W:0]    hi2_next    [NUM_WINDOWS][NUM_RATIOS];
    logic [SCALED_W-1:0] scaled2_next [NUM_RATIOS];
    logic [ENTRY_W-1:0]  lo2_reg     [NUM_WINDOWS][NUM_RATIOS];
    logic [ENTRY_W:0]    hi2_reg     [NUM_WINDOWS][NUM_RATIOS];
    logic [SCALED_W-1:0] scaled2_reg [NUM_RATIOS];
    logic [CHAN_W-1:0]   den2_reg    [NUM_RATIOS];
    logic                bad2_reg;

    // Stage 3: bounds times denominators.
    logic [LO_PROD_W-1:0] lo3_next    [NUM_WINDOWS][NUM_RATIOS];
    logic [HI_PROD_W-1:0] hi3_next    [NUM_WINDOWS][NUM_RATIOS];
    logic [LO_PROD_W-1:0] lo3_reg     [NUM_WINDOWS][NUM_RATIOS];
    logic [HI_PROD_W-1:0] hi3_reg     [NUM_WINDOWS][NUM_RATIOS];
    logic [SCALED_W-1:0]  scaled3_reg [NUM_RATIOS];
    logic                 bad3_reg;

    // Stage 4: compares and pick.
    logic [NUM_WINDOWS-1:0] match;
    logic [COLOR_W-1:0]     color_next;
    logic [COLOR_W-1:0]     color_reg;

    assign num[0] = red;
    assign den[0] = green;
    assign num[1] = red;
    assign den[1] = blue;
    assign num[2] = green;
    assign den[2] = blue;

    // A lower bound below zero always holds, so it is clamped to zero.
    always_comb begin
        for (int w = 0; w < NUM_WINDOWS; w++) begin
            for (int q = 0; q < NUM_RATIOS; q++) begin
                if (cal_row[WIN_BASE + w * NUM_RATIOS + q] >= cal_row[q]) begin
                    lo2_next[w][q] = cal_row[WIN_BASE + w * NUM_RATIOS + q] - cal_row[q];
                end else begin
                    lo2_next[w][q] = '0;
                end
                hi2_next[w][q] = {1'b0, cal_row[WIN_BASE + w * NUM_RATIOS + q]}
                               + {1'b0, cal_row[q]};
            end
        end
        for (int q = 0; q < NUM_RATIOS; q++) begin
            scaled2_next[q] = SCALED_W'(num[q]) * SCALED_W'(RATIO_SCALE);
        end
    end

    always_ff @(posedge aclk) begin
        if (ctl.ld2) begin
            lo2_reg     <= lo2_next;
            hi2_reg     <= hi2_next;
            scaled2_reg <= scaled2_next;
            den2_reg    <= den;
            bad2_reg    <= bad;
        end
    end

    always_comb begin
        for (int w = 0; w < NUM_WINDOWS; w++) begin
            for (int q = 0; q < NUM_RATIOS; q++) begin
                lo3_next[w][q] = LO_PROD_W'(lo2_reg[w][q]) * LO_PROD_W'(den2_reg[q]);
                hi3_next[w][q] = HI_PROD_W'(hi2_reg[w][q]) * HI_PROD_W'(den2_reg[q]);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (ctl.ld3) begin
            lo3_reg     <= lo3_next;
            hi3_reg     <= hi3_next;
            scaled3_reg <= scaled2_reg;
            bad3_reg    <= bad2_reg;
        end
    end

    always_comb begin
        for (int w = 0; w < NUM_WINDOWS; w++) begin
            match[w] = 1'b1;
            for (int q = 0; q < NUM_RATIOS; q++) begin
                if ((LO_PROD_W'(scaled3_reg[q]) < lo3_reg[w][q]) ||
                    (HI_PROD_W'(scaled3_reg[q]) > hi3_reg[w][q])) begin
                    match[w] = 1'b0;
                end
            end
        end
        priority if (bad3_reg) begin
            color_next = LIGHT_NONE;
        end else if (match[0]) begin
            color_next = LIGHT_MIDDLE;
        end else if (match[1]) begin
            color_next = LIGHT_WHITE;
        end else if (match[2]) begin
            color_next = LIGHT_YELLOW;
        end else begin
            color_next = LIGHT_NONE;
        end
    end

    always_ff @(posedge aclk) begin
        if (ctl.ld4) begin
            color_reg <= color_next;
        end
    end

    assign color = color_reg;

endmodule

/* sv/rgb_ratio_color_classifier_top.sv */
// ----------------------------------------------------------------------------
// RGB ratio color classifier
// An accepted classify item passes the table read, bound add, multiply and compare
// stages in that order, the last being the output register that drives m_tvalid.
// Throughput: 1 item per cycle unless m_tready stalls a full pipeline; a write item gives no result.
// Reset: aresetn clears the stage valid flags and the entry valid flags, so
// every calibration entry reads its built-in default until it is written.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module rgb_ratio_color_classifier_top (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    // sensor[2:0], red[18:3], green[34:19], blue[50:35], param_index[54:51],
    // param_value[62:55], zero[63]
    input  logic [rgbrcc_pkg::S_TDATA_W-1:0]   s_tdata,
    // cmd[0]
    input  logic                               s_tuser,
    output logic                               m_tvalid,
    input  logic                               m_tready,
    // color[1:0], zero[7:2]
    output logic [rgbrcc_pkg::M_TDATA_W-1:0]   m_tdata
);

    import rgbrcc_pkg::*;

    logic [SENSOR_W-1:0] s_sensor;
    logic [CHAN_W-1:0]   s_red;
    logic [CHAN_W-1:0]   s_green;
    logic [CHAN_W-1:0]   s_blue;
    logic [IDX_W-1:0]    s_param_index;
    logic [VALUE_W-1:0]  s_param_value;

    logic      accept;
    logic      wr_en;
    logic      rdy1, rdy2, rdy3, rdy4;
    pipe_ctl_t ctl;

    logic v1_reg, v2_reg, v3_reg, v4_reg;
    logic v1_next, v2_next, v3_next, v4_next;

    logic [CHAN_W-1:0]  red_s1_reg;
    logic [CHAN_W-1:0]  green_s1_reg;
    logic [CHAN_W-1:0]  blue_s1_reg;
    logic               bad_s1_reg;
    logic               bad_next;
    cal_row_t           cal_row;
    logic [COLOR_W-1:0] color;

    assign s_sensor      = s_tdata[2:0];
    assign s_red         = s_tdata[18:3];
    assign s_green       = s_tdata[34:19];
    assign s_blue        = s_tdata[50:35];
    assign s_param_index = s_tdata[54:51];
    assign s_param_value = s_tdata[62:55];

    // A stage may take new data when it is empty or its contents move on.
    assign rdy4     = !v4_reg || m_tready;
    assign rdy3     = !v3_reg || rdy4;
    assign rdy2     = !v2_reg || rdy3;
    assign rdy1     = !v1_reg || rdy2;
    assign s_tready = rdy1;

    assign accept  = s_tvalid && s_tready;
    assign ctl.ld1 = accept && (s_tuser == CMD_CLASSIFY);
    assign ctl.ld2 = v1_reg && rdy2;
    assign ctl.ld3 = v2_reg && rdy3;
    assign ctl.ld4 = v3_reg && rdy4;

    assign wr_en = accept && (s_tuser == CMD_WRITE)
                 && (int'(s_sensor) < NUM_SENSORS) && (int'(s_param_index) < ENTRIES);

    assign bad_next = (int'(s_sensor) >= NUM_SENSORS) || (s_green == '0) || (s_blue == '0);

    assign v1_next = rdy1 ? ctl.ld1 : v1_reg;
    assign v2_next = rdy2 ? v1_reg  : v2_reg;
    assign v3_next = rdy3 ? v2_reg  : v3_reg;
    assign v4_next = rdy4 ? v3_reg  : v4_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end else begin
            v1_reg <= v1_next;
            v2_reg <= v2_next;
            v3_reg <= v3_next;
            v4_reg <= v4_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (ctl.ld1) begin
            red_s1_reg   <= s_red;
            green_s1_reg <= s_green;
            blue_s1_reg  <= s_blue;
            bad_s1_reg   <= bad_next;
        end
    end

    rgbrcc_cal_store u_cal_store (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .ctl      (ctl),
        .wr_en    (wr_en),
        .wr_sensor(s_sensor),
        .wr_index (s_param_index),
        .wr_value (s_param_value),
        .rd_sensor(s_sensor),
        .cal_row  (cal_row)
    );

    rgbrcc_window_pipe u_window_pipe (
        .aclk   (aclk),
        .ctl    (ctl),
        .cal_row(cal_row),
        .red    (red_s1_reg),
        .green  (green_s1_reg),
        .blue   (blue_s1_reg),
        .bad    (bad_s1_reg),
        .color  (color)
    );

    assign m_tvalid = v4_reg;
    assign m_tdata  = M_TDATA_W'(color);

`ifndef SYNTH
    // A write item never enters the pipeline.
    a_write_no_result: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && (s_tuser == CMD_WRITE)) |=> !v1_reg)
        else $error("write item entered the pipeline");

    // Every accepted classify item occupies the first stage.
    a_classify_enters: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && (s_tuser == CMD_CLASSIFY)) |=> v1_reg)
        else $error("classify item lost at the first stage");

    // An item in the first stage that cannot move on stays there.
    a_stage1_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        (v1_reg && !ctl.ld2) |=> v1_reg)
        else $error("first stage item dropped during a stall");

    // With all stages full and the output stalled, no item is taken.
    a_full_stalls: assert property (@(posedge aclk) disable iff (!aresetn)
        (v1_reg && v2_reg && v3_reg && v4_reg && !m_tready) |-> !s_tready)
        else $error("item taken while the pipeline is full");
`endif

endmodule
